// File: src/icmc_pkg.sv
// ----------------------------------------------------------------------------
// icmc_pkg
// shared constants, types and helpers of the consensus mismatch counter
// ----------------------------------------------------------------------------
package icmc_pkg;

    localparam int DEF_MAX_MOTIF = 32;
    localparam int CFG_W         = 64;
    localparam int CFG_IDX_W     = 2;
    localparam int LEN_W         = 6;
    localparam int CNT_W         = 6;
    localparam int CHAR_W        = 8;
    localparam int CODE_W        = 3;
    localparam int CONS_POS      = 32;
    localparam int CONS_HALF     = 16;

    localparam logic [CFG_IDX_W-1:0] REG_CONS_LOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CONS_HIGH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MOTIF_LEN = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_MISS  = 2'd3;

    localparam logic [CHAR_W-1:0] CHAR_A = 8'd65;
    localparam logic [CHAR_W-1:0] CHAR_C = 8'd67;
    localparam logic [CHAR_W-1:0] CHAR_G = 8'd71;
    localparam logic [CHAR_W-1:0] CHAR_T = 8'd84;

    localparam logic [CODE_W-1:0] CODE_A   = 3'd0;
    localparam logic [CODE_W-1:0] CODE_C   = 3'd1;
    localparam logic [CODE_W-1:0] CODE_G   = 3'd2;
    localparam logic [CODE_W-1:0] CODE_T   = 3'd3;
    localparam logic [CODE_W-1:0] CODE_BAD = 3'd4;

    typedef logic [CONS_POS-1:0][3:0] t_masks;

    typedef struct packed {
        logic             load;
        logic             rev;
        logic [LEN_W-1:0] len;
    } t_cell_ctrl;

    function automatic logic [CODE_W-1:0] encode_base(input logic [CHAR_W-1:0] ch);
        logic [CODE_W-1:0] code;
        case (ch)
            CHAR_A:  code = CODE_A;
            CHAR_C:  code = CODE_C;
            CHAR_G:  code = CODE_G;
            CHAR_T:  code = CODE_T;
            default: code = CODE_BAD;
        endcase
        return code;
    endfunction

endpackage

// File: src/icmc_cell.sv
// ----------------------------------------------------------------------------
// icmc_cell
// one window position: holds a base code, passes it on, flags a mismatch
// ----------------------------------------------------------------------------
module icmc_cell #(
    parameter int IDX = 0
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  icmc_pkg::t_cell_ctrl          i_ctrl,
    input  icmc_pkg::t_masks              i_masks,
    input  logic [icmc_pkg::CODE_W-1:0]   i_code,
    output logic [icmc_pkg::CODE_W-1:0]   o_code,
    output logic                          o_miss
);

    localparam logic [icmc_pkg::LEN_W-1:0] L_IDX = icmc_pkg::LEN_W'(IDX);

    logic [icmc_pkg::CODE_W-1:0] r_code;
    logic                        r_miss;
    logic                        n_miss;
    logic                        active;
    logic [icmc_pkg::LEN_W-1:0]  pos;
    logic [3:0]                  mask;
    logic [1:0]                  code_eff;

    always_comb begin
        active   = L_IDX < i_ctrl.len;
        pos      = i_ctrl.rev ? L_IDX : (i_ctrl.len - L_IDX - icmc_pkg::LEN_W'(1));
        mask     = (pos < icmc_pkg::LEN_W'(icmc_pkg::CONS_POS)) ? i_masks[pos[4:0]] : 4'd0;
        code_eff = i_ctrl.rev ? (2'd3 - i_code[1:0]) : i_code[1:0];
        n_miss   = active && (i_code[2] || !mask[code_eff]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_code <= icmc_pkg::CODE_BAD;
        end else if (i_ctrl.load) begin
            r_code <= i_code;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_miss <= n_miss;
        end
    end

    assign o_code = r_code;
    assign o_miss = r_miss;

endmodule

// File: src/icmc_count_tree.sv
// ----------------------------------------------------------------------------
// icmc_count_tree
// registered group counts of the mismatch flags and their final sum
// ----------------------------------------------------------------------------
module icmc_count_tree #(
    parameter int N = icmc_pkg::DEF_MAX_MOTIF
) (
    input  logic                         i_clk,
    input  logic                         i_en,
    input  logic [N-1:0]                 i_miss,
    output logic [$clog2(N+1)-1:0]       o_sum
);

    localparam int NG    = (N + 7) / 8;
    localparam int SUM_W = $clog2(N + 1);

    logic [NG*8-1:0]      miss_pad;
    logic [NG-1:0][3:0]   n_grp;
    logic [NG-1:0][3:0]   r_grp;
    logic [SUM_W-1:0]     sum;

    always_comb begin
        miss_pad = '0;
        miss_pad[N-1:0] = i_miss;
        for (int g = 0; g < NG; g++) begin
            n_grp[g] = 4'($countones(miss_pad[g*8 +: 8]));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_grp <= n_grp;
        end
    end

    always_comb begin
        sum = '0;
        for (int g = 0; g < NG; g++) begin
            sum = sum + SUM_W'(r_grp[g]);
        end
    end

    assign o_sum = sum;

endmodule

// File: src/iupac_consensus_mismatch_count.sv
// ----------------------------------------------------------------------------
// iupac_consensus_mismatch_count
// sliding-window mismatch count of a dna byte stream against an iupac mask
// ----------------------------------------------------------------------------
// Bases enter as ASCII bytes with a strand bit on the i_valid/o_stall input
// channel; each transaction yields one result (mismatch count, window full,
// within limit) on the o_valid/i_stall output channel. The window is a row
// of MAX_MOTIF cells that shift one base per accepted transaction; each cell
// flags its own mismatch, and a two-level registered adder sums the flags.
// One transaction is taken every cycle while the output side does not
// stall. When i_stall holds a result, the whole pipe freezes and o_stall
// rises on the input side. Configuration (consensus masks, motif length,
// mismatch limit) is written through i_cfg_we/i_cfg_idx/i_cfg_data; the
// user must do so only while no transaction is in flight; the block does not
// enforce this. Synchronous reset clears the window to invalid bases, the
// fill count to zero, the masks to zero, motif length to 1 and limit to 0.
// ----------------------------------------------------------------------------
module iupac_consensus_mismatch_count #(
    parameter int MAX_MOTIF = icmc_pkg::DEF_MAX_MOTIF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [icmc_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [icmc_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic [icmc_pkg::CHAR_W-1:0]    i_base_char,
    input  logic                           i_strand,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic [icmc_pkg::CNT_W-1:0]     o_mismatch_count,
    output logic                           o_window_full,
    output logic                           o_within_limit
);

    localparam int SUM_W = $clog2(MAX_MOTIF + 1);
    localparam int LIM_W = icmc_pkg::LEN_W + 1;

    logic [icmc_pkg::CFG_W-1:0]   r_cons_low;
    logic [icmc_pkg::CFG_W-1:0]   r_cons_high;
    logic [icmc_pkg::LEN_W-1:0]   r_motif_len;
    logic [icmc_pkg::LEN_W-1:0]   r_max_miss;
    logic [icmc_pkg::LEN_W-1:0]   r_fill;
    logic [icmc_pkg::LEN_W-1:0]   n_fill;
    logic                         r_v1;
    logic                         r_v2;
    logic                         r_full1;
    logic                         r_full2;
    logic                         r_out_valid;
    logic [icmc_pkg::CNT_W-1:0]   r_count;
    logic                         r_full_out;
    logic                         r_within;
    logic                         adv;
    logic                         accept;
    logic [icmc_pkg::LEN_W-1:0]   len;
    icmc_pkg::t_masks             masks;
    icmc_pkg::t_cell_ctrl         ctrl;
    logic [MAX_MOTIF:0][icmc_pkg::CODE_W-1:0] chain;
    logic [MAX_MOTIF-1:0]         miss;
    logic [SUM_W-1:0]             sum;
    logic [LIM_W-1:0]             limit;
    logic [LIM_W-1:0]             sum_ext;
    logic [LIM_W-1:0]             n_count;

    assign adv     = !r_out_valid || !i_stall;
    assign accept  = i_valid && adv;
    assign o_stall = !adv;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cons_low  <= '0;
            r_cons_high <= '0;
            r_motif_len <= icmc_pkg::LEN_W'(1);
            r_max_miss  <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                icmc_pkg::REG_CONS_LOW:  r_cons_low  <= i_cfg_data;
                icmc_pkg::REG_CONS_HIGH: r_cons_high <= i_cfg_data;
                icmc_pkg::REG_MOTIF_LEN: r_motif_len <= i_cfg_data[icmc_pkg::LEN_W-1:0];
                icmc_pkg::REG_MAX_MISS:  r_max_miss  <= i_cfg_data[icmc_pkg::LEN_W-1:0];
                default: ;
            endcase
        end
    end

    // effective motif length and mask array
    always_comb begin
        len = r_motif_len;
        if (len == '0) begin
            len = icmc_pkg::LEN_W'(1);
        end
        if (32'(len) > MAX_MOTIF) begin
            len = icmc_pkg::LEN_W'(MAX_MOTIF);
        end
        for (int p = 0; p < icmc_pkg::CONS_HALF; p++) begin
            masks[p]                       = r_cons_low[p*4 +: 4];
            masks[p + icmc_pkg::CONS_HALF] = r_cons_high[p*4 +: 4];
        end
    end

    assign ctrl.load = accept;
    assign ctrl.rev  = i_strand;
    assign ctrl.len  = len;

    assign chain[0] = icmc_pkg::encode_base(i_base_char);

    for (genvar e = 0; e < MAX_MOTIF; e++) begin : g_cell
        icmc_cell #(
            .IDX (e)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctrl  (ctrl),
            .i_masks (masks),
            .i_code  (chain[e]),
            .o_code  (chain[e+1]),
            .o_miss  (miss[e])
        );
    end

    // fill count, saturating
    assign n_fill = (r_fill == '1) ? r_fill : r_fill + icmc_pkg::LEN_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else if (accept) begin
            r_fill <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_full1 <= n_fill >= len;
        end
        if (adv) begin
            r_full2 <= r_full1;
        end
    end

    icmc_count_tree #(
        .N (MAX_MOTIF)
    ) u_tree (
        .i_clk  (i_clk),
        .i_en   (adv),
        .i_miss (miss),
        .o_sum  (sum)
    );

    // saturation and limit check
    always_comb begin
        limit   = LIM_W'(r_max_miss) + LIM_W'(1);
        sum_ext = LIM_W'(sum);
        n_count = (sum_ext > limit) ? limit : sum_ext;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_v1        <= i_valid;
            r_v2        <= r_v1;
            r_out_valid <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_count    <= n_count[icmc_pkg::CNT_W-1:0];
            r_full_out <= r_full2;
            r_within   <= r_full2 && (n_count <= LIM_W'(r_max_miss));
        end
    end

    assign o_valid          = r_out_valid;
    assign o_mismatch_count = r_count;
    assign o_window_full    = r_full_out;
    assign o_within_limit   = r_within;

endmodule

// File: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the iupac consensus mismatch counter
// ----------------------------------------------------------------------------
// A table of directed bases runs first (reset state, byte extremes, both
// strands, zero and oversized motif length, unfilled window, large limit),
// then random blocks that mostly plant consensus matches with mutations,
// mixed with noise. Every accepted transaction is scored by an in-bench
// window model, or for pinned directed rows by the table's expected result,
// and compared with the block's output in order. Both channels idle and
// stall at random; configuration changes only between drained blocks.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int PIPE_LAT       = 3;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int BLOCK_ITEMS    = 55;
    localparam int N_DIR          = 24;
    localparam logic FWD = 1'b0;
    localparam logic REV = 1'b1;
    localparam logic [2:0] SETUP_NONE = 3'd7;

    typedef struct packed {
        logic [icmc_pkg::CNT_W-1:0] count;
        logic                       full;
        logic                       in_limit;
    } t_score;

    typedef struct packed {
        logic [icmc_pkg::CFG_W-1:0] lo;
        logic [icmc_pkg::CFG_W-1:0] hi;
        logic [icmc_pkg::LEN_W-1:0] len;
        logic [icmc_pkg::CNT_W-1:0] lim;
    } t_setup;

    typedef struct packed {
        logic [2:0]                  setup;
        logic [icmc_pkg::CHAR_W-1:0] ch;
        logic                        rev;
        logic                        pinned;
        t_score                      exp;
    } t_row;

    localparam logic [icmc_pkg::CHAR_W-1:0] BASES [0:3] = '{
        icmc_pkg::CHAR_A, icmc_pkg::CHAR_C, icmc_pkg::CHAR_G, icmc_pkg::CHAR_T
    };

    localparam t_setup DIR_SETUPS [0:4] = '{
        '{64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 6'd32, 6'd63},
        '{64'h1111_1111_1111_1111, 64'h8888_8888_8888_8888, 6'd0,  6'd0},
        '{64'h0000_0000_0000_0000, 64'hFFFF_FFFF_FFFF_FFFF, 6'd63, 6'd5},
        '{64'h0000_0000_8421_F3C5, 64'h0000_0000_0000_0000, 6'd8,  6'd2},
        '{64'h0000_0000_0000_0842, 64'h0000_0000_0000_0000, 6'd3,  6'd1}
    };

    localparam t_row DIR_ROWS [0:N_DIR-1] = '{
        // reset config: single position, empty mask
        '{SETUP_NONE, icmc_pkg::CHAR_A, FWD, 1'b1, '{6'd1, 1'b1, 1'b0}},
        '{SETUP_NONE, 8'h00,            REV, 1'b1, '{6'd1, 1'b1, 1'b0}},
        '{SETUP_NONE, 8'hFF,            FWD, 1'b1, '{6'd1, 1'b1, 1'b0}},
        '{SETUP_NONE, icmc_pkg::CHAR_T, REV, 1'b1, '{6'd1, 1'b1, 1'b0}},
        '{SETUP_NONE, 8'h61,            FWD, 1'b1, '{6'd1, 1'b1, 1'b0}},
        // full length, any base allowed, window not yet full
        '{3'd0,       icmc_pkg::CHAR_C, FWD, 1'b0, '0},
        '{SETUP_NONE, icmc_pkg::CHAR_G, REV, 1'b0, '0},
        '{SETUP_NONE, 8'h80,            FWD, 1'b0, '0},
        // zero length acts as one, position 0 allows only a
        '{3'd1,       icmc_pkg::CHAR_A, FWD, 1'b1, '{6'd0, 1'b1, 1'b1}},
        '{SETUP_NONE, icmc_pkg::CHAR_T, REV, 1'b1, '{6'd0, 1'b1, 1'b1}},
        '{SETUP_NONE, icmc_pkg::CHAR_C, FWD, 1'b1, '{6'd1, 1'b1, 1'b0}},
        '{SETUP_NONE, icmc_pkg::CHAR_G, REV, 1'b1, '{6'd1, 1'b1, 1'b0}},
        '{SETUP_NONE, 8'h2A,            FWD, 1'b1, '{6'd1, 1'b1, 1'b0}},
        // oversized length clamps to the window
        '{3'd2,       icmc_pkg::CHAR_G, FWD, 1'b0, '0},
        '{SETUP_NONE, icmc_pkg::CHAR_A, REV, 1'b0, '0},
        // length shrinks mid-stream
        '{3'd3,       icmc_pkg::CHAR_A, FWD, 1'b0, '0},
        '{SETUP_NONE, icmc_pkg::CHAR_G, FWD, 1'b0, '0},
        '{SETUP_NONE, icmc_pkg::CHAR_T, REV, 1'b0, '0},
        '{SETUP_NONE, icmc_pkg::CHAR_C, FWD, 1'b0, '0},
        '{SETUP_NONE, 8'h7F,            REV, 1'b0, '0},
        '{3'd4,       icmc_pkg::CHAR_A, REV, 1'b0, '0},
        '{SETUP_NONE, icmc_pkg::CHAR_C, REV, 1'b0, '0},
        '{SETUP_NONE, icmc_pkg::CHAR_G, REV, 1'b0, '0},
        '{SETUP_NONE, icmc_pkg::CHAR_T, FWD, 1'b0, '0}
    };

    logic                           i_clk = 1'b0;
    logic                           i_rst_n;
    logic                           i_cfg_we;
    logic [icmc_pkg::CFG_IDX_W-1:0] i_cfg_idx;
    logic [icmc_pkg::CFG_W-1:0]     i_cfg_data;
    logic                           i_valid;
    logic                           o_stall;
    logic [icmc_pkg::CHAR_W-1:0]    i_base_char;
    logic                           i_strand;
    logic                           o_valid;
    logic                           i_stall;
    logic [icmc_pkg::CNT_W-1:0]     o_mismatch_count;
    logic                           o_window_full;
    logic                           o_within_limit;

    iupac_consensus_mismatch_count dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_base_char      (i_base_char),
        .i_strand         (i_strand),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_mismatch_count (o_mismatch_count),
        .o_window_full    (o_window_full),
        .o_within_limit   (o_within_limit)
    );

    always #4 i_clk = ~i_clk;

    // window model state
    logic [icmc_pkg::CODE_W-1:0] seq_window [icmc_pkg::DEF_MAX_MOTIF];
    int                          bases_seen;
    logic [icmc_pkg::CFG_W-1:0]  mask_lo;
    logic [icmc_pkg::CFG_W-1:0]  mask_hi;
    logic [icmc_pkg::LEN_W-1:0]  motif_len;
    logic [icmc_pkg::CNT_W-1:0]  mm_limit;

    t_score expected_scores [$];
    int     items_in;
    int     idle_cycles;
    int     fail_count = 0;
    int     tx_pct;
    int     rx_pct;
    logic   hold_req = 1'b0;
    t_setup cur_setup;

    function automatic int clamp_len(input logic [icmc_pkg::LEN_W-1:0] len);
        if (len == 0)
            return 1;
        if (len > icmc_pkg::DEF_MAX_MOTIF)
            return icmc_pkg::DEF_MAX_MOTIF;
        return int'(len);
    endfunction

    function automatic t_score score_window(input logic [icmc_pkg::CHAR_W-1:0] ch,
                                            input logic rev);
        t_score                      s;
        logic [icmc_pkg::CODE_W-1:0] code;
        logic [127:0]                masks;
        int                          len;
        int                          pos;
        int                          misses;
        int                          cap;
        for (int k = icmc_pkg::DEF_MAX_MOTIF - 1; k > 0; k--)
            seq_window[k] = seq_window[k-1];
        case (ch)
            icmc_pkg::CHAR_A: code = icmc_pkg::CODE_A;
            icmc_pkg::CHAR_C: code = icmc_pkg::CODE_C;
            icmc_pkg::CHAR_G: code = icmc_pkg::CODE_G;
            icmc_pkg::CHAR_T: code = icmc_pkg::CODE_T;
            default:          code = icmc_pkg::CODE_BAD;
        endcase
        seq_window[0] = code;
        if (bases_seen < 63)
            bases_seen++;
        len = clamp_len(motif_len);
        masks = {mask_hi, mask_lo};
        misses = 0;
        // on the forward strand the oldest base sits at window position 0, on the reverse strand the newest
        for (int k = 0; k < len; k++) begin
            code = seq_window[len-1-k];
            pos = k;
            if (code == icmc_pkg::CODE_BAD) begin
                misses++;
            end else begin
                if (rev) begin
                    code = icmc_pkg::CODE_T - code;
                    pos = len - 1 - k;
                end
                if (!masks[4*pos + code])
                    misses++;
            end
        end
        cap = mm_limit + 1;
        s.count = icmc_pkg::CNT_W'((misses > cap) ? cap : misses);
        s.full = (bases_seen >= len);
        s.in_limit = s.full && (s.count <= mm_limit);
        return s;
    endfunction

    task automatic flag_error(input string msg);
        fail_count++;
        if (fail_count <= 10)
            $display("%s", msg);
    endtask

    // scoreboard, prediction and watchdog
    always @(posedge i_clk) begin : scoreboard
        t_score want;
        t_score got;
        logic   moved;
        if (!i_rst_n) begin
            for (int k = 0; k < icmc_pkg::DEF_MAX_MOTIF; k++)
                seq_window[k] = icmc_pkg::CODE_BAD;
            bases_seen = 0;
            mask_lo = '0;
            mask_hi = '0;
            motif_len = icmc_pkg::LEN_W'(1);
            mm_limit = '0;
            items_in = 0;
            idle_cycles = 0;
        end else begin
            moved = 1'b0;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    icmc_pkg::REG_CONS_LOW:  mask_lo = i_cfg_data;
                    icmc_pkg::REG_CONS_HIGH: mask_hi = i_cfg_data;
                    icmc_pkg::REG_MOTIF_LEN: motif_len = i_cfg_data[icmc_pkg::LEN_W-1:0];
                    icmc_pkg::REG_MAX_MISS:  mm_limit = i_cfg_data[icmc_pkg::CNT_W-1:0];
                    default: ;
                endcase
            end
            if (o_valid && !i_stall) begin
                moved = 1'b1;
                got.count = o_mismatch_count;
                got.full = o_window_full;
                got.in_limit = o_within_limit;
                if (expected_scores.size() == 0) begin
                    flag_error($sformatf("unexpected result: count %0d full %0b within %0b",
                                         got.count, got.full, got.in_limit));
                end else begin
                    want = expected_scores.pop_front();
                    if (want.count != got.count || want.full != got.full ||
                        want.in_limit != got.in_limit)
                        flag_error($sformatf({"result mismatch: expected count %0d full %0b ",
                                              "within %0b, got count %0d full %0b within %0b"},
                                             want.count, want.full, want.in_limit,
                                             got.count, got.full, got.in_limit));
                end
            end
            if (i_valid && !o_stall) begin
                moved = 1'b1;
                want = score_window(i_base_char, i_strand);
                if (items_in < N_DIR && DIR_ROWS[items_in].pinned)
                    want = DIR_ROWS[items_in].exp;
                expected_scores.insert(expected_scores.size(), want);
                items_in++;
            end
            idle_cycles = moved ? 0 : idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    // result side back-pressure
    initial begin : receiver
        int hold;
        i_stall = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                i_stall <= 1'b1;
                for (hold = 0; hold < HOLD_CYCLES; hold++)
                    @(posedge i_clk);
                i_stall <= 1'b0;
            end else begin
                i_stall <= ($urandom_range(99) < rx_pct);
            end
        end
    end

    task automatic push_base(input logic [icmc_pkg::CHAR_W-1:0] ch, input logic rev);
        int gap;
        gap = 0;
        while (gap < 30 && $urandom_range(99) < tx_pct)
            gap++;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_base_char <= ch;
        i_strand <= rev;
        do @(posedge i_clk); while (o_stall);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (expected_scores.size() != 0)
            @(posedge i_clk);
        repeat (PIPE_LAT + 2) @(posedge i_clk);
    endtask

    task automatic apply_setup(input t_setup s);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= icmc_pkg::REG_CONS_LOW;
        i_cfg_data <= s.lo;
        @(posedge i_clk);
        i_cfg_idx <= icmc_pkg::REG_CONS_HIGH;
        i_cfg_data <= s.hi;
        @(posedge i_clk);
        i_cfg_idx <= icmc_pkg::REG_MOTIF_LEN;
        i_cfg_data <= icmc_pkg::CFG_W'(s.len);
        @(posedge i_clk);
        i_cfg_idx <= icmc_pkg::REG_MAX_MISS;
        i_cfg_data <= icmc_pkg::CFG_W'(s.lim);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // one consensus hit on a random strand, with occasional point mutations
    task automatic plant_motif(output int n);
        logic [127:0]                masks;
        logic [3:0]                  m;
        logic [icmc_pkg::CHAR_W-1:0] ch;
        logic                        rev;
        int                          b;
        n = clamp_len(cur_setup.len);
        masks = {cur_setup.hi, cur_setup.lo};
        rev = 1'($urandom_range(1));
        for (int i = 0; i < n; i++) begin
            m = masks[4*(rev ? n - 1 - i : i) +: 4];
            if (m == 4'h0) begin
                b = $urandom_range(3);
            end else begin
                do b = $urandom_range(3); while (!m[b]);
            end
            ch = rev ? BASES[3-b] : BASES[b];
            if ($urandom_range(99) < 8)
                ch = ($urandom_range(3) == 0) ? icmc_pkg::CHAR_W'($urandom_range(255))
                                               : BASES[$urandom_range(3)];
            push_base(ch, rev);
        end
    endtask

    initial begin : stimulus
        t_setup                      s;
        logic [127:0]                all_masks;
        logic [icmc_pkg::CHAR_W-1:0] ch;
        int                          sent;
        int                          n;
        int                          sel;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_base_char = '0;
        i_strand = FWD;
        i_cfg_we = 1'b0;
        i_cfg_idx = icmc_pkg::REG_CONS_LOW;
        i_cfg_data = '0;
        tx_pct = 6;
        rx_pct = 68;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int r = 0; r < N_DIR; r++) begin
            if (DIR_ROWS[r].setup != SETUP_NONE) begin
                drain();
                cur_setup = DIR_SETUPS[DIR_ROWS[r].setup];
                apply_setup(cur_setup);
            end
            push_base(DIR_ROWS[r].ch, DIR_ROWS[r].rev);
        end

        for (int mode = 0; mode < 3; mode++) begin
            tx_pct = (mode == 0) ? 6 : (mode == 1) ? 68 : 0;
            rx_pct = (mode == 0) ? 68 : (mode == 1) ? 6 : 0;
            for (int blk = 0; blk < 6; blk++) begin
                drain();
                for (int p = 0; p < icmc_pkg::CONS_POS; p++) begin
                    sel = $urandom_range(99);
                    if (sel < 50)
                        all_masks[4*p +: 4] = 4'b0001 << $urandom_range(3);
                    else if (sel < 85)
                        all_masks[4*p +: 4] = 4'($urandom_range(1, 15));
                    else if (sel < 95)
                        all_masks[4*p +: 4] = 4'hF;
                    else
                        all_masks[4*p +: 4] = 4'h0;
                end
                s.lo = all_masks[63:0];
                s.hi = all_masks[127:64];
                sel = $urandom_range(99);
                if (sel < 80)
                    s.len = icmc_pkg::LEN_W'($urandom_range(1, 12));
                else if (sel < 90)
                    s.len = icmc_pkg::LEN_W'($urandom_range(13, 32));
                else if (sel < 95)
                    s.len = '0;
                else
                    s.len = icmc_pkg::LEN_W'($urandom_range(33, 63));
                sel = $urandom_range(99);
                if (sel < 70)
                    s.lim = icmc_pkg::CNT_W'($urandom_range(0, 3));
                else if (sel < 90)
                    s.lim = icmc_pkg::CNT_W'($urandom_range(0, 32));
                else
                    s.lim = icmc_pkg::CNT_W'($urandom_range(33, 63));
                cur_setup = s;
                apply_setup(s);
                if (mode == 0 && blk == 0)
                    hold_req = 1'b1;
                sent = 0;
                while (sent < BLOCK_ITEMS) begin
                    if ($urandom_range(99) < 65) begin
                        plant_motif(n);
                    end else begin
                        n = $urandom_range(1, 6);
                        repeat (n) begin
                            ch = ($urandom_range(99) < 80)
                                 ? BASES[$urandom_range(3)]
                                 : icmc_pkg::CHAR_W'($urandom_range(255));
                            push_base(ch, 1'($urandom_range(1)));
                        end
                    end
                    sent += n;
                end
            end
        end

        drain();
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
